FILE: design/serial_packet_deframer_xor_check_unit_defines.svh
// Assertion macros used by the checker file of the deframer.
`ifndef SERIAL_PACKET_DEFRAMER_XOR_CHECK_UNIT_DEFINES_SVH
`define SERIAL_PACKET_DEFRAMER_XOR_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SDXC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SDXC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/sdxc_pkg.sv
// Types and constants of the serial packet deframer.
package sdxc_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned NIBBLE_W = 4;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PREAMBLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_PREAMBLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS   = 2'd2;

   localparam logic [BYTE_W-1:0] FIRST_PREAMBLE_RESET  = 8'd170;
   localparam logic [BYTE_W-1:0] SECOND_PREAMBLE_RESET = 8'd85;
   localparam logic [BYTE_W-1:0] TIMEOUT_TICKS_RESET   = 8'd5;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_IDLE = 1'b1;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD     = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [NIBBLE_W-1:0] group;
      logic [NIBBLE_W-1:0] device_id;
      logic [BYTE_W-1:0]   command_code;
      logic [BYTE_W-1:0]   payload_length;
      logic [BYTE_W-1:0]   payload_byte;
      logic [BYTE_W-1:0]   byte_index;
   } rsp_type;

   // classified word handed from front to back
   typedef struct packed {
      logic              is_idle;
      logic              first_hit;
      logic              second_hit;
      logic [BYTE_W-1:0] data_byte;
   } item_type;

   // settings the back end needs from the register file
   typedef struct packed {
      logic [BYTE_W-1:0] timeout_ticks;
      logic [BYTE_W-1:0] preamble_xor;
   } ctrl_type;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_SYNC2,
      PH_HEADER,
      PH_COMMAND,
      PH_LENGTH,
      PH_BODY
   } phase_type;

endpackage

FILE: design/sdxc_front.sv
// Front end: configuration registers and classification of incoming words.
module sdxc_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  sdxc_pkg::req_type                       req_data,
   output logic                                    req_stall,
   input  logic                                    csr_write_en,
   input  logic [sdxc_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [sdxc_pkg::BYTE_W-1:0]             csr_write_data,
   input  logic                                    queue_full,
   output logic                                    push,
   output sdxc_pkg::item_type                      item,
   output sdxc_pkg::ctrl_type                      ctrl
);

   logic [sdxc_pkg::BYTE_W-1:0] first_preamble_ff, first_preamble_in;
   logic [sdxc_pkg::BYTE_W-1:0] second_preamble_ff, second_preamble_in;
   logic [sdxc_pkg::BYTE_W-1:0] timeout_ticks_ff, timeout_ticks_in;

   always_comb begin
      first_preamble_in  = first_preamble_ff;
      second_preamble_in = second_preamble_ff;
      timeout_ticks_in   = timeout_ticks_ff;
      if (csr_write_en) begin
         case (csr_index)
            sdxc_pkg::CSR_FIRST_PREAMBLE:  first_preamble_in  = csr_write_data;
            sdxc_pkg::CSR_SECOND_PREAMBLE: second_preamble_in = csr_write_data;
            sdxc_pkg::CSR_TIMEOUT_TICKS:   timeout_ticks_in   = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_preamble_ff  <= sdxc_pkg::FIRST_PREAMBLE_RESET;
         second_preamble_ff <= sdxc_pkg::SECOND_PREAMBLE_RESET;
         timeout_ticks_ff   <= sdxc_pkg::TIMEOUT_TICKS_RESET;
      end else begin
         first_preamble_ff  <= first_preamble_in;
         second_preamble_ff <= second_preamble_in;
         timeout_ticks_ff   <= timeout_ticks_in;
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      item.is_idle    = (req_data.cmd == sdxc_pkg::CMD_IDLE);
      item.first_hit  = (req_data.data_byte == first_preamble_ff);
      item.second_hit = (req_data.data_byte == second_preamble_ff);
      item.data_byte  = req_data.data_byte;
   end

   assign ctrl = '{timeout_ticks: timeout_ticks_ff,
                   preamble_xor:  first_preamble_ff ^ second_preamble_ff};

endmodule

FILE: design/sdxc_queue.sv
// Short queue of classified words between front and back.
module sdxc_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sdxc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output sdxc_pkg::item_type pop_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   sdxc_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: design/sdxc_back.sv
// Back end: frame parser, checksum, idle timer and result register.
module sdxc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  sdxc_pkg::item_type pop_item,
   output logic               pop,
   input  sdxc_pkg::ctrl_type ctrl,
   output logic               rsp_valid,
   output sdxc_pkg::rsp_type  rsp_data,
   input  logic               rsp_stall
);

   sdxc_pkg::phase_type phase_ff, phase_in;

   logic [sdxc_pkg::BYTE_W-1:0]   countdown_ff, countdown_in;
   logic [sdxc_pkg::BYTE_W-1:0]   xor_ff, xor_in;
   logic [sdxc_pkg::BYTE_W-1:0]   index_ff, index_in;
   logic [sdxc_pkg::NIBBLE_W-1:0] group_ff, group_in;
   logic [sdxc_pkg::NIBBLE_W-1:0] device_ff, device_in;
   logic [sdxc_pkg::BYTE_W-1:0]   command_ff, command_in;
   logic [sdxc_pkg::BYTE_W-1:0]   length_ff, length_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sdxc_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                          take;
   logic                          emit;
   logic                          expire;
   logic                          body_end;
   logic [sdxc_pkg::BYTE_W-1:0]   xor_next;

   assign take     = pop_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop      = take;
   assign expire   = pop_item.is_idle && (countdown_ff == 8'd1);
   assign body_end = (index_ff == length_ff);
   assign xor_next = xor_ff ^ pop_item.data_byte;

   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         if (pop_item.is_idle) begin
            if (expire) begin
               phase_in = sdxc_pkg::PH_HUNT;
            end
         end else begin
            case (phase_ff)
               sdxc_pkg::PH_HUNT:
                  phase_in = pop_item.first_hit ? sdxc_pkg::PH_SYNC2 : sdxc_pkg::PH_HUNT;
               sdxc_pkg::PH_SYNC2:
                  phase_in = pop_item.second_hit ? sdxc_pkg::PH_HEADER : sdxc_pkg::PH_HUNT;
               sdxc_pkg::PH_HEADER:  phase_in = sdxc_pkg::PH_COMMAND;
               sdxc_pkg::PH_COMMAND: phase_in = sdxc_pkg::PH_LENGTH;
               sdxc_pkg::PH_LENGTH:  phase_in = sdxc_pkg::PH_BODY;
               sdxc_pkg::PH_BODY:
                  phase_in = body_end ? sdxc_pkg::PH_HUNT : sdxc_pkg::PH_BODY;
               default:              phase_in = sdxc_pkg::PH_HUNT;
            endcase
         end
      end
   end

   always_comb begin
      countdown_in = countdown_ff;
      xor_in       = xor_ff;
      index_in     = index_ff;
      group_in     = group_ff;
      device_in    = device_ff;
      command_in   = command_ff;
      length_in    = length_ff;
      emit         = 1'b0;
      rsp_data_in  = '0;
      if (take) begin
         if (pop_item.is_idle) begin
            if (countdown_ff != '0) begin
               countdown_in = countdown_ff - 1'b1;
            end
            if (expire) begin
               emit             = 1'b1;
               rsp_data_in.kind = sdxc_pkg::KIND_TIMEOUT;
            end
         end else begin
            countdown_in = ctrl.timeout_ticks;
            case (phase_ff)
               sdxc_pkg::PH_SYNC2: begin
                  xor_in = ctrl.preamble_xor;
               end
               sdxc_pkg::PH_HEADER: begin
                  group_in  = pop_item.data_byte[sdxc_pkg::BYTE_W-1:sdxc_pkg::NIBBLE_W];
                  device_in = pop_item.data_byte[sdxc_pkg::NIBBLE_W-1:0];
                  xor_in    = xor_next;
               end
               sdxc_pkg::PH_COMMAND: begin
                  command_in = pop_item.data_byte;
                  xor_in     = xor_next;
               end
               sdxc_pkg::PH_LENGTH: begin
                  length_in = pop_item.data_byte;
                  index_in  = '0;
                  xor_in    = xor_next;
               end
               sdxc_pkg::PH_BODY: begin
                  xor_in                     = xor_next;
                  emit                       = 1'b1;
                  rsp_data_in.group          = group_ff;
                  rsp_data_in.device_id      = device_ff;
                  rsp_data_in.command_code   = command_ff;
                  rsp_data_in.payload_length = length_ff;
                  if (body_end) begin
                     countdown_in     = '0;
                     rsp_data_in.kind = (xor_next == '0) ? sdxc_pkg::KIND_GOOD
                                                         : sdxc_pkg::KIND_BAD;
                  end else begin
                     index_in                 = index_ff + 1'b1;
                     rsp_data_in.kind         = sdxc_pkg::KIND_PAYLOAD;
                     rsp_data_in.payload_byte = pop_item.data_byte;
                     rsp_data_in.byte_index   = index_ff;
                  end
               end
               default: ;
            endcase
         end
      end
      rsp_valid_in = take ? emit : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sdxc_pkg::PH_HUNT;
         countdown_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         countdown_ff <= countdown_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xor_ff     <= xor_in;
      index_ff   <= index_in;
      group_ff   <= group_in;
      device_ff  <= device_in;
      command_ff <= command_in;
      length_ff  <= length_in;
      if (take && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/serial_packet_deframer_xor_check_unit.sv
// Top level of the serial packet deframer with XOR checksum.
//
// req channel: one word per accepted cycle, either a received byte or an
// idle tick. The parser hunts for two sync bytes, then reads header,
// command and length bytes, the payload and a checksum byte.
// rsp channel: at most one word per request word: a payload byte with its
// index, a good or bad frame report at the checksum byte, or a timeout when
// idle ticks run the inter-byte timer down.
// csr port: writes to the two sync byte values and the timeout length; the user
// must write them only while the block is idle, which the block does not enforce.
// Path: an accepted request word is written into the queue register; its result,
// if any, goes to the result register when the parser takes the word.
// Throughput: one word per cycle while rsp_stall does not hold the result.
// Reset: the parser returns to the hunt, the timer stops, the queue and
// result register empty, and the registers take their default values.
// A stall on rsp holds the result; the queue then fills and req_stall
// rises once it holds QUEUE_DEPTH words.
module serial_packet_deframer_xor_check_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  sdxc_pkg::req_type              req_data,
   output logic                           req_stall,
   output logic                           rsp_valid,
   output sdxc_pkg::rsp_type              rsp_data,
   input  logic                           rsp_stall,
   input  logic                           csr_write_en,
   input  logic [sdxc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sdxc_pkg::BYTE_W-1:0]    csr_write_data
);

   logic               queue_full;
   logic               push;
   logic               pop;
   logic               pop_valid;
   sdxc_pkg::item_type push_item;
   sdxc_pkg::item_type pop_item;
   sdxc_pkg::ctrl_type ctrl;

   sdxc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_data       (req_data),
      .req_stall      (req_stall),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .queue_full     (queue_full),
      .push           (push),
      .item           (push_item),
      .ctrl           (ctrl)
   );

   sdxc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   sdxc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop       (pop),
      .ctrl      (ctrl),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

FILE: design/sdxc_checker.sv
// Port-level checks of the deframer and their binding to the top level.
`include "serial_packet_deframer_xor_check_unit_defines.svh"

module sdxc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input sdxc_pkg::rsp_type rsp_data,
   input logic              rsp_stall
);

   `SDXC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result word changed")
   `SDXC_ASSERT_NOW(a_report_clean, clock, reset, rsp_valid && (rsp_data.kind != sdxc_pkg::KIND_PAYLOAD), (rsp_data.payload_byte == '0) && (rsp_data.byte_index == '0), "report word carries payload data")
   `SDXC_ASSERT_NOW(a_timeout_clean, clock, reset, rsp_valid && (rsp_data.kind == sdxc_pkg::KIND_TIMEOUT), (rsp_data.group == '0) && (rsp_data.device_id == '0) && (rsp_data.command_code == '0) && (rsp_data.payload_length == '0), "timeout word carries header data")
   `SDXC_ASSERT_NOW(a_index_range, clock, reset, rsp_valid && (rsp_data.kind == sdxc_pkg::KIND_PAYLOAD), rsp_data.byte_index < rsp_data.payload_length, "payload index beyond declared length")

endmodule

bind serial_packet_deframer_xor_check_unit sdxc_checker u_sdxc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .rsp_stall (rsp_stall)
);

FILE: dv/deframer_checker.sv
// Deframer checker: tracks the frame parser, predicts each result word and compares.
module deframer_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  sdxc_pkg::req_type              req_data,
   input  logic                           req_stall,
   input  logic                           rsp_valid,
   input  sdxc_pkg::rsp_type              rsp_data,
   input  logic                           rsp_stall,
   input  logic                           csr_write_en,
   input  logic [sdxc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sdxc_pkg::BYTE_W-1:0]    csr_write_data,
   output int                             failures,
   output int                             outstanding
);

   localparam logic [8:0] POS_HUNT       = 9'd0;
   localparam logic [8:0] POS_SYNC2      = 9'd1;
   localparam logic [8:0] POS_HEADER     = 9'd2;
   localparam logic [8:0] POS_COMMAND    = 9'd3;
   localparam logic [8:0] POS_LENGTH     = 9'd4;
   localparam logic [8:0] PAYLOAD_START  = 9'd5;
   localparam logic [8:0] FRAME_OVERHEAD = 9'd6;

   logic [sdxc_pkg::BYTE_W-1:0]   first_sync;
   logic [sdxc_pkg::BYTE_W-1:0]   second_sync;
   logic [sdxc_pkg::BYTE_W-1:0]   idle_limit;

   logic [8:0]                    position;
   logic [8:0]                    frame_total;
   logic [sdxc_pkg::BYTE_W-1:0]   running_xor;
   logic [sdxc_pkg::NIBBLE_W-1:0] hdr_group;
   logic [sdxc_pkg::NIBBLE_W-1:0] hdr_device;
   logic [sdxc_pkg::BYTE_W-1:0]   hdr_command;
   logic [sdxc_pkg::BYTE_W-1:0]   hdr_length;
   logic [sdxc_pkg::BYTE_W-1:0]   idle_countdown;

   sdxc_pkg::rsp_type             pending_reports[$];

   initial failures = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t deframer: %s", $time, msg);
      failures++;
   endtask

   function automatic sdxc_pkg::rsp_type make_report(
         input logic [1:0] kind, input logic with_header,
         input logic [sdxc_pkg::BYTE_W-1:0] pbyte,
         input logic [sdxc_pkg::BYTE_W-1:0] pindex);
      sdxc_pkg::rsp_type r;
      r.kind           = kind;
      r.group          = with_header ? hdr_group : '0;
      r.device_id      = with_header ? hdr_device : '0;
      r.command_code   = with_header ? hdr_command : '0;
      r.payload_length = with_header ? hdr_length : '0;
      r.payload_byte   = pbyte;
      r.byte_index     = pindex;
      return r;
   endfunction

   function automatic void advance_parser(input sdxc_pkg::req_type w);
      logic [8:0] idx;
      if (w.cmd == sdxc_pkg::CMD_IDLE) begin
         if (idle_countdown != 0) begin
            idle_countdown--;
            if (idle_countdown == 0) begin
               position = POS_HUNT;
               pending_reports.push_back(
                  make_report(sdxc_pkg::KIND_TIMEOUT, 1'b0, '0, '0));
            end
         end
      end else begin
         idle_countdown = idle_limit;
         case (position)
            POS_HUNT: begin
               position = (w.data_byte == first_sync) ? POS_SYNC2 : POS_HUNT;
            end
            POS_SYNC2: begin
               if (w.data_byte == second_sync) begin
                  running_xor = first_sync ^ second_sync;
                  position    = POS_HEADER;
               end else begin
                  position = POS_HUNT;
               end
            end
            POS_HEADER: begin
               hdr_group   = w.data_byte[7:4];
               hdr_device  = w.data_byte[3:0];
               running_xor ^= w.data_byte;
               position    = POS_COMMAND;
            end
            POS_COMMAND: begin
               hdr_command = w.data_byte;
               running_xor ^= w.data_byte;
               position    = POS_LENGTH;
            end
            POS_LENGTH: begin
               hdr_length  = w.data_byte;
               frame_total = {1'b0, w.data_byte} + FRAME_OVERHEAD;
               running_xor ^= w.data_byte;
               position    = PAYLOAD_START;
            end
            default: begin
               if (position < frame_total) begin
                  idx = position - PAYLOAD_START;
                  running_xor ^= w.data_byte;
                  if (idx < {1'b0, hdr_length})
                     pending_reports.push_back(
                        make_report(sdxc_pkg::KIND_PAYLOAD, 1'b1, w.data_byte, idx[7:0]));
                  position++;
               end
            end
         endcase
         if (position != POS_HUNT && position == frame_total) begin
            pending_reports.push_back(
               make_report(running_xor == 0 ? sdxc_pkg::KIND_GOOD : sdxc_pkg::KIND_BAD,
                           1'b1, '0, '0));
            idle_countdown = '0;
            position       = POS_HUNT;
         end
      end
   endfunction

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   task automatic check_report(input sdxc_pkg::rsp_type got);
      sdxc_pkg::rsp_type want;
      if (pending_reports.size() == 0) begin
         report_mismatch($sformatf("result word %h with nothing pending", got));
      end else begin
         want = pending_reports.pop_front();
         check_field("kind", 8'(got.kind), 8'(want.kind));
         check_field("group", 8'(got.group), 8'(want.group));
         check_field("device_id", 8'(got.device_id), 8'(want.device_id));
         check_field("command_code", got.command_code, want.command_code);
         check_field("payload_length", got.payload_length, want.payload_length);
         check_field("payload_byte", got.payload_byte, want.payload_byte);
         check_field("byte_index", got.byte_index, want.byte_index);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         first_sync     = sdxc_pkg::FIRST_PREAMBLE_RESET;
         second_sync    = sdxc_pkg::SECOND_PREAMBLE_RESET;
         idle_limit     = sdxc_pkg::TIMEOUT_TICKS_RESET;
         position       = POS_HUNT;
         frame_total    = '0;
         running_xor    = '0;
         hdr_group      = '0;
         hdr_device     = '0;
         hdr_command    = '0;
         hdr_length     = '0;
         idle_countdown = '0;
         pending_reports.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_report(rsp_data);
         if (req_valid && !req_stall)
            advance_parser(req_data);
         if (csr_write_en) begin
            case (csr_index)
               sdxc_pkg::CSR_FIRST_PREAMBLE:  first_sync  = csr_write_data;
               sdxc_pkg::CSR_SECOND_PREAMBLE: second_sync = csr_write_data;
               sdxc_pkg::CSR_TIMEOUT_TICKS:   idle_limit  = csr_write_data;
               default: ;
            endcase
         end
      end
      outstanding = pending_reports.size();
   end

endmodule

FILE: dv/testbench.sv
// Testbench top: clock, reset, frame and noise stimulus, settings phases and verdict.
module testbench;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   sdxc_pkg::req_type              req_data;
   logic                           req_stall;
   logic                           rsp_valid;
   sdxc_pkg::rsp_type              rsp_data;
   logic                           rsp_stall;
   logic                           csr_write_en;
   logic [sdxc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [sdxc_pkg::BYTE_W-1:0]    csr_write_data;
   int                             failures;
   int                             outstanding;

   logic [sdxc_pkg::BYTE_W-1:0]    cfg_first;
   logic [sdxc_pkg::BYTE_W-1:0]    cfg_second;
   logic [sdxc_pkg::BYTE_W-1:0]    cfg_timeout;
   int                             sent_words = 0;
   int                             burst_left = 0;
   bit                             long_hold_done = 1'b0;

   always #5 clock = ~clock;

   serial_packet_deframer_xor_check_unit u_top (.*);

   deframer_checker u_checker (.*);

   task automatic send_word(input logic cmd, input logic [sdxc_pkg::BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{cmd: cmd, data_byte: b};
      do @(posedge clock); while (req_stall);
      sent_words++;
   endtask

   task automatic maybe_idle();
      int ticks;
      int top_ticks;
      ticks     = 0;
      top_ticks = (cfg_timeout == 0 || cfg_timeout > 9) ? 8 : cfg_timeout - 1;
      if ($urandom_range(0, 39) == 0)
         ticks = cfg_timeout;
      else if (cfg_timeout != 1 && $urandom_range(0, 11) == 0)
         ticks = $urandom_range(1, top_ticks);
      repeat (ticks) send_word(sdxc_pkg::CMD_IDLE, 8'($urandom));
   endtask

   task automatic send_frame();
      logic [sdxc_pkg::BYTE_W-1:0] hdr, code, len, sum, b;
      int total, cut, r;
      hdr  = 8'($urandom);
      code = 8'($urandom);
      r    = $urandom_range(0, 99);
      if (r < 2)
         len = 8'd255;
      else if (r < 5)
         len = 8'($urandom_range(9, 254));
      else
         len = 8'($urandom_range(0, 8));
      total = len + 6;
      cut   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total - 1) : total;
      sum   = cfg_first ^ cfg_second ^ hdr ^ code ^ len;
      for (int i = 0; i < cut; i++) begin
         if (i == 0)
            b = cfg_first;
         else if (i == 1)
            b = cfg_second;
         else if (i == 2)
            b = hdr;
         else if (i == 3)
            b = code;
         else if (i == 4)
            b = len;
         else if (i < total - 1) begin
            b = 8'($urandom);
            sum ^= b;
         end else begin
            b = ($urandom_range(0, 3) == 0) ? sum ^ 8'($urandom_range(1, 255)) : sum;
         end
         if (i > 0)
            maybe_idle();
         send_word(sdxc_pkg::CMD_BYTE, b);
      end
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0:       send_word(sdxc_pkg::CMD_IDLE, 8'($urandom));
            1:       send_word(sdxc_pkg::CMD_BYTE, cfg_first);
            2:       send_word(sdxc_pkg::CMD_BYTE, cfg_second);
            default: send_word(sdxc_pkg::CMD_BYTE, 8'($urandom));
         endcase
      end
   endtask

   task automatic finish_phase();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [sdxc_pkg::BYTE_W-1:0] f,
                                 input logic [sdxc_pkg::BYTE_W-1:0] s,
                                 input logic [sdxc_pkg::BYTE_W-1:0] t);
      cfg_first      = f;
      cfg_second     = s;
      cfg_timeout    = t;
      csr_write_en   <= 1'b1;
      csr_index      <= sdxc_pkg::CSR_FIRST_PREAMBLE;
      csr_write_data <= f;
      @(posedge clock);
      csr_index      <= sdxc_pkg::CSR_SECOND_PREAMBLE;
      csr_write_data <= s;
      @(posedge clock);
      csr_index      <= sdxc_pkg::CSR_TIMEOUT_TICKS;
      csr_write_data <= t;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   initial begin
      logic [sdxc_pkg::BYTE_W-1:0] opening[20];
      logic [sdxc_pkg::BYTE_W-1:0] phase_first[7];
      logic [sdxc_pkg::BYTE_W-1:0] phase_second[7];
      logic [sdxc_pkg::BYTE_W-1:0] phase_timeout[7];
      int phase_end;
      req_valid      <= 1'b0;
      req_data       <= '0;
      csr_write_en   <= 1'b0;
      csr_index      <= '0;
      csr_write_data <= '0;
      reset          <= 1'b1;
      cfg_first   = sdxc_pkg::FIRST_PREAMBLE_RESET;
      cfg_second  = sdxc_pkg::SECOND_PREAMBLE_RESET;
      cfg_timeout = sdxc_pkg::TIMEOUT_TICKS_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // good frame, idle with timer stopped, failed sync, empty frame with bad sum, timeout
      opening = '{8'hAA, 8'h55, 8'hF0, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'h0D,
                  8'hAA, 8'hAA, 8'h55,
                  8'hAA, 8'h55, 8'h0F, 8'h00, 8'h00, 8'h0F,
                  8'hAA, 8'h55, 8'h3C};
      foreach (opening[i]) begin
         send_word(sdxc_pkg::CMD_BYTE, opening[i]);
         if (i == 7)
            send_word(sdxc_pkg::CMD_IDLE, 8'($urandom));
      end
      repeat (cfg_timeout) send_word(sdxc_pkg::CMD_IDLE, 8'($urandom));

      phase_first   = '{sdxc_pkg::FIRST_PREAMBLE_RESET, 8'h00, 8'hFF, 8'h7E, 8'($urandom),
                        8'($urandom), 8'hAA};
      phase_second  = '{sdxc_pkg::SECOND_PREAMBLE_RESET, 8'hFF, 8'h00, 8'h7E, 8'($urandom),
                        8'($urandom), 8'h55};
      phase_timeout = '{sdxc_pkg::TIMEOUT_TICKS_RESET, 8'd1, 8'd255, 8'd3, 8'd0,
                        8'($urandom_range(1, 255)), 8'd2};
      for (int p = 0; p < 7; p++) begin
         if (p > 0) begin
            finish_phase();
            apply_settings(phase_first[p], phase_second[p], phase_timeout[p]);
         end
         phase_end = sent_words + 300;
         while (sent_words < phase_end) begin
            if ($urandom_range(0, 9) < 7)
               send_frame();
            else
               send_noise();
         end
      end
      finish_phase();

      if (failures == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      int mode;
      int stretch;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(20, 200);
         repeat (stretch) begin
            // hold off long enough to back up the queue into the input
            if (!long_hold_done && sent_words >= 400) begin
               rsp_stall <= 1'b1;
               repeat (80) @(posedge clock);
               long_hold_done = 1'b1;
            end
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      #2000000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
